// File: sv/ttl_pkg.sv
// Package for the telemetry terminal link unit: beat types, opcodes, states
// and default sizes. No dependencies.

package ttl_pkg;

    localparam int DISPLAY_CHARS_DEF  = 32;
    localparam int LINE_ONE_START_DEF = 1;
    localparam int LINE_TWO_START_DEF = 17;

    localparam int DELAY_W = 8;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd10;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] START_BYTE = 8'hFE;
    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam logic [3:0] NIBBLE_ONES = 4'hF;

    // clear_line selector codes; anything else clears the whole display
    localparam logic [1:0] CLR_ALL   = 2'd0;
    localparam logic [1:0] CLR_LINE1 = 2'd1;
    localparam logic [1:0] CLR_LINE2 = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_RX_BYTE   = 3'd1,
        OP_TX_SLOT   = 3'd2,
        OP_WRITE_CHR = 3'd3,
        OP_SET_CUR   = 3'd4,
        OP_CLEAR     = 3'd5,
        OP_READ_BTN  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_CLEAR,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] rx_byte;
        logic       rx_ninth;
        logic       rx_error;
        logic [7:0] char_in;
        logic [5:0] cursor_position;
        logic [1:0] clear_line;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_ninth;
        logic       frame_done;
        logic [3:0] button_value;
    } t_result;

endpackage

// File: sv/ttl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module ttl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/telemetry_terminal_link_unit.sv
// Telemetry terminal link unit: display store, cursor, button report and frame sender.
// Depends on ttl_pkg and ttl_ram.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+---------------------------
//  in      | i_in_valid | o_in_ready  | i_in_data  (t_item)
//  res     | o_res_valid| i_res_ready | o_res_data (t_result)
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_data (reply delay)
//
// Flow: one beat in, one beat out. The sequencer takes an item in IDLE, runs it in
// EXEC and hands the result over in FIN. A frame data slot adds the READ state for
// the registered store read. A clear sweeps its positions one at a time in CLEAR over
// the single store write port (16, 16 and 32 positions at default sizes).
// Reset: synchronous, active low; store positions read as spaces through per-entry
// valid bits cleared at once, so no sweep after reset.
// Stalls: the result register frees the sequencer; a new item is taken while an old
// result waits, and FIN holds only when that register is still full.

module telemetry_terminal_link_unit #(
    parameter int DISPLAY_CHARS  = ttl_pkg::DISPLAY_CHARS_DEF,
    parameter int LINE_ONE_START = ttl_pkg::LINE_ONE_START_DEF,
    parameter int LINE_TWO_START = ttl_pkg::LINE_TWO_START_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ttl_pkg::t_item               i_in_data,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output ttl_pkg::t_result             o_res_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ttl_pkg::DELAY_W-1:0]  i_cfg_data
);
    import ttl_pkg::*;

    localparam int DEPTH = DISPLAY_CHARS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(DISPLAY_CHARS + 3);

    localparam logic [AW-1:0] LAST_POS  = AW'(DISPLAY_CHARS);
    localparam logic [SW-1:0] SEND_END  = SW'(DISPLAY_CHARS + 1);
    localparam logic [AW-1:0] CUR_HOME  =
        AW'((LINE_ONE_START > DISPLAY_CHARS) ? DISPLAY_CHARS : LINE_ONE_START);
    localparam logic [AW-1:0] CUR_LINE2 =
        AW'((LINE_TWO_START > DISPLAY_CHARS) ? DISPLAY_CHARS : LINE_TWO_START);

    // clear ranges, clipped to the store
    localparam int  L1_END_I = (LINE_TWO_START - 1 > DISPLAY_CHARS) ?
                               DISPLAY_CHARS : LINE_TWO_START - 1;
    localparam logic [AW-1:0] L1_START = AW'(LINE_ONE_START);
    localparam logic [AW-1:0] L1_END   = AW'(L1_END_I);
    localparam logic          L1_EMPTY = LINE_ONE_START > L1_END_I;
    localparam logic          L2_EMPTY = LINE_TWO_START > DISPLAY_CHARS;
    localparam logic [AW-1:0] L2_START = AW'(L2_EMPTY ? 0 : LINE_TWO_START);

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic [DELAY_W-1:0] r_delay;
    logic [AW-1:0]      r_cursor, n_cursor;
    logic [SW-1:0]      r_send, n_send;
    logic               r_sending, n_sending;
    logic [DELAY_W-1:0] r_count, n_count;
    logic [3:0]         r_btn, n_btn;
    logic [3:0]         r_last, n_last;
    logic [DEPTH-1:0]   r_valid;
    logic [AW-1:0]      r_addr, n_addr;
    logic [AW-1:0]      r_end, n_end;
    logic               r_rd_vld, n_rd_vld;
    t_result            r_res, n_res;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;

    ttl_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_out_valid;
    assign o_res_data  = r_out;
    assign ram_raddr   = r_send[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_delay     <= DELAY_RESET;
            r_cursor    <= CUR_HOME;
            r_send      <= '0;
            r_sending   <= 1'b0;
            r_count     <= '0;
            r_btn       <= '0;
            r_last      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_send      <= n_send;
            r_sending   <= n_sending;
            r_count     <= n_count;
            r_btn       <= n_btn;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_delay <= i_cfg_data;
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_addr   <= n_addr;
        r_end    <= n_end;
        r_rd_vld <= n_rd_vld;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_cursor    = r_cursor;
        n_send      = r_send;
        n_sending   = r_sending;
        n_count     = r_count;
        n_btn       = r_btn;
        n_last      = r_last;
        n_addr      = r_addr;
        n_end       = r_end;
        n_rd_vld    = r_rd_vld;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = SPACE_CHAR;
        ram_re      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res   = '0;
                n_state = ST_FIN;
                case (r_item.operation)
                    OP_TICK: begin
                        if (r_count == DELAY_W'(1)) begin
                            n_count   = '0;
                            n_sending = 1'b1;
                        end else if (r_count != '0) begin
                            n_count = r_count - DELAY_W'(1);
                        end
                    end
                    OP_RX_BYTE: begin
                        if (!r_item.rx_error && !r_item.rx_ninth &&
                            r_item.rx_byte[3:0] == 4'h0) begin
                            n_btn   = r_item.rx_byte[7:4] ^ NIBBLE_ONES;
                            n_count = r_delay;
                        end
                    end
                    OP_TX_SLOT: begin
                        if (r_sending) begin
                            if (r_send == '0) begin
                                n_res.tx_valid = 1'b1;
                                n_res.tx_byte  = START_BYTE;
                                n_send         = SW'(1);
                            end else if (r_send == SEND_END) begin
                                n_res.tx_valid = 1'b1;
                                n_res.tx_byte  = END_BYTE;
                                n_send         = r_send + SW'(1);
                            end else if (r_send > SEND_END) begin
                                n_res.frame_done = 1'b1;
                                n_sending        = 1'b0;
                                n_send           = '0;
                            end else begin
                                // display position: fetch from the store
                                ram_re   = 1'b1;
                                n_rd_vld = r_valid[ram_raddr];
                                n_state  = ST_READ;
                            end
                        end
                    end
                    OP_WRITE_CHR: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_cursor;
                        ram_wdata = r_item.char_in;
                        if (r_cursor != LAST_POS) begin
                            n_cursor = r_cursor + AW'(1);
                        end
                    end
                    OP_SET_CUR: begin
                        if (int'(r_item.cursor_position) > DISPLAY_CHARS) begin
                            n_cursor = LAST_POS;
                        end else begin
                            n_cursor = AW'(r_item.cursor_position);
                        end
                    end
                    OP_CLEAR: begin
                        case (r_item.clear_line)
                            CLR_LINE1: begin
                                n_cursor = CUR_HOME;
                                n_addr   = L1_START;
                                n_end    = L1_END;
                                if (!L1_EMPTY) begin
                                    n_state = ST_CLEAR;
                                end
                            end
                            CLR_LINE2: begin
                                n_cursor = CUR_LINE2;
                                n_addr   = L2_START;
                                n_end    = LAST_POS;
                                if (!L2_EMPTY) begin
                                    n_state = ST_CLEAR;
                                end
                            end
                            default: begin
                                n_cursor = CUR_HOME;
                                n_addr   = L1_START;
                                n_end    = LAST_POS;
                                n_state  = ST_CLEAR;
                            end
                        endcase
                    end
                    OP_READ_BTN: begin
                        if (r_last != r_btn) begin
                            n_last             = r_btn;
                            n_res.button_value = r_btn;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_READ: begin
                n_res.tx_valid = 1'b1;
                n_res.tx_byte  = r_rd_vld ? ram_rdata : SPACE_CHAR;
                n_res.tx_ninth = 1'b1;
                n_send         = r_send + SW'(1);
                n_state        = ST_FIN;
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = SPACE_CHAR;
                if (r_addr == r_end) begin
                    n_state = ST_FIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/ttl_checker.sv
// Port-level checks for the telemetry terminal link unit, bound to the top level.
// Depends on ttl_pkg and telemetry_terminal_link_unit.

module ttl_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input ttl_pkg::t_result o_res_data,
    input logic             o_res_valid,
    input logic             i_res_ready
);
    import ttl_pkg::*;

    // a held result beat keeps its payload
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res_data))
        else $error("result beat changed while stalled");

    // the sequencer is not ready in the cycle after taking an item
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken on consecutive cycles");

    a_done_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res_data.frame_done |->
            !o_res_data.tx_valid && o_res_data.button_value == 4'h0)
        else $error("frame close carries data");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res_data.tx_valid |->
            o_res_data.tx_byte == 8'h00 && !o_res_data.tx_ninth)
        else $error("byte fields set without a sent byte");

    a_ctrl_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res_data.tx_valid && !o_res_data.tx_ninth |->
            o_res_data.tx_byte == START_BYTE || o_res_data.tx_byte == END_BYTE)
        else $error("control byte is neither start nor end marker");

endmodule

bind telemetry_terminal_link_unit ttl_checker u_ttl_checker (.*);

// File: sim/tb_telemetry_terminal_link_unit.sv
// Self-checking bench for telemetry_terminal_link_unit: a predictor of the display store,
// cursor, button report and frame sender checks every result beat. Depends on ttl_pkg.

module tb_telemetry_terminal_link_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ttl_pkg::*;

    localparam int CHARS      = DISPLAY_CHARS_DEF;
    localparam int LINE_ONE   = LINE_ONE_START_DEF;
    localparam int LINE_TWO   = LINE_TWO_START_DEF;
    // one clear sweeps the whole display: allow for it before a delay write and at the end
    localparam int SETTLE_CYCLES = 48;
    // ~1300 beats, each at its worst (sweep, long gap, long stall), taken ~5x
    localparam int CYCLE_LIMIT   = 800_000;

    // ---------------------------------------------------------------- DUT signals
    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_item            in_data  = '0;
    logic             res_valid;
    logic             res_ready = 1'b0;
    t_result          res_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [DELAY_W-1:0] cfg_data = '0;

    telemetry_terminal_link_unit #(
        .DISPLAY_CHARS  (CHARS),
        .LINE_ONE_START (LINE_ONE),
        .LINE_TWO_START (LINE_TWO)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_data  (res_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- bookkeeping
    t_item              pending_items[$];
    t_result            expected_results[$];
    logic [DELAY_W-1:0] delay_writes[$];

    int  pushed_cnt    = 0;
    int  accepted_cnt  = 0;
    int  checked_cnt   = 0;
    int  mismatch_cnt  = 0;
    int  delay_done    = 0;
    int  frames_closed = 0;
    int  cycle_cnt     = 0;
    int  in_gap        = 0;
    int  res_hold      = 0;
    bit  quiet         = 1'b0;   // stretches where neither side idles

    // ---------------------------------------------------------------- terminal predictor
    logic [DELAY_W-1:0] m_delay;
    logic [7:0]         m_store [0:CHARS];
    logic [5:0]         m_cursor;
    logic [5:0]         m_send_idx;
    logic               m_sending;
    logic [7:0]         m_countdown;
    logic [3:0]         m_buttons;
    logic [3:0]         m_last_read;

    function automatic logic [5:0] clamp_cursor(int v);
        return (v > CHARS) ? 6'(CHARS) : 6'(v);
    endfunction

    function automatic void blank_store(int from, int upto);
        for (int p = from; p <= upto && p <= CHARS; p++)
            m_store[p] = SPACE_CHAR;
    endfunction

    // Applies one item to the predicted state and returns the result it must give.
    function automatic t_result advance_terminal(t_item it);
        t_result r;
        r = '0;
        case (it.operation)
            OP_TICK: begin
                if (m_countdown == 8'd1) begin
                    m_countdown = '0;
                    m_sending   = 1'b1;
                end else if (m_countdown > 8'd1) begin
                    m_countdown = m_countdown - 8'd1;
                end
            end
            OP_RX_BYTE: begin
                // only a clean control byte with an empty low nibble is a report
                if (!it.rx_error && !it.rx_ninth && it.rx_byte[3:0] == 4'h0) begin
                    m_buttons   = ~it.rx_byte[7:4];
                    m_countdown = m_delay;
                end
            end
            OP_TX_SLOT: begin
                if (m_sending) begin
                    if (m_send_idx == 0) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = START_BYTE;
                        m_send_idx = 6'd1;
                    end else if (m_send_idx == CHARS + 1) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = END_BYTE;
                        m_send_idx = 6'(CHARS + 2);
                    end else if (m_send_idx >= CHARS + 2) begin
                        r.frame_done = 1'b1;
                        m_sending    = 1'b0;
                        m_send_idx   = '0;
                        frames_closed++;
                    end else begin
                        // store contents as they stand now, writes mid-frame included
                        r.tx_valid = 1'b1;
                        r.tx_byte  = m_store[m_send_idx];
                        r.tx_ninth = 1'b1;
                        m_send_idx = m_send_idx + 6'd1;
                    end
                end
            end
            OP_WRITE_CHR: begin
                m_store[m_cursor] = it.char_in;
                if (m_cursor < CHARS)
                    m_cursor = m_cursor + 6'd1;
            end
            OP_SET_CUR: m_cursor = clamp_cursor(it.cursor_position);
            OP_CLEAR: begin
                case (it.clear_line)
                    CLR_LINE1: begin
                        blank_store(LINE_ONE, LINE_TWO - 1);
                        m_cursor = clamp_cursor(LINE_ONE);
                    end
                    CLR_LINE2: begin
                        blank_store(LINE_TWO, CHARS);
                        m_cursor = clamp_cursor(LINE_TWO);
                    end
                    default: begin
                        blank_store(LINE_ONE, CHARS);
                        m_cursor = clamp_cursor(LINE_ONE);
                    end
                endcase
            end
            OP_READ_BTN: begin
                if (m_last_read != m_buttons) begin
                    m_last_read    = m_buttons;
                    r.button_value = m_buttons;
                end
            end
            default: ;  // unused opcode does nothing
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- random helpers
    // Mostly back-to-back, some short pauses, the odd long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Every field random, so that unused fields still toggle.
    function automatic t_item fresh_item(logic [2:0] op);
        t_item it;
        it.operation       = op;
        it.rx_byte         = 8'($urandom);
        it.rx_ninth        = 1'($urandom);
        it.rx_error        = 1'($urandom);
        it.char_in         = 8'($urandom);
        it.cursor_position = 6'($urandom);
        it.clear_line      = 2'($urandom);
        return it;
    endfunction

    function automatic t_item button_report();
        t_item it;
        it = fresh_item(OP_RX_BYTE);
        it.rx_byte[3:0] = 4'h0;
        it.rx_ninth     = 1'b0;
        it.rx_error     = 1'b0;
        return it;
    endfunction

    function automatic t_item host_item();
        t_item it;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            it = fresh_item(OP_WRITE_CHR);
        end else if (r < 65) begin
            it = fresh_item(OP_SET_CUR);
            if ($urandom_range(0, 9) < 7)
                it.cursor_position = 6'($urandom_range(0, CHARS));
        end else if (r < 80) begin
            it = fresh_item(OP_CLEAR);
        end else begin
            it = fresh_item(OP_READ_BTN);
        end
        return it;
    endfunction

    // Anything at all, or a report spoilt in one respect.
    function automatic t_item noise_item();
        t_item it;
        if ($urandom_range(0, 9) < 7)
            return fresh_item(3'($urandom_range(0, 7)));
        it = button_report();
        case ($urandom_range(0, 2))
            0:       it.rx_error     = 1'b1;
            1:       it.rx_ninth     = 1'b1;
            default: it.rx_byte[3:0] = 4'($urandom_range(1, 15));
        endcase
        return it;
    endfunction

    task automatic push_item(t_item it);
        pending_items.push_back(it);
        pushed_cnt++;
    endtask

    // Host traffic, a report, enough ticks to expire the countdown, then a full frame
    // of ready slots with host writes, re-reports and ticks scattered through it.
    task automatic gen_frame(int delay_value);
        int ticks;
        int slots;
        int r;
        repeat ($urandom_range(0, 4)) push_item(host_item());
        push_item(button_report());
        ticks = (delay_value == 0) ? $urandom_range(0, 3) : delay_value + $urandom_range(0, 2);
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_item(host_item());
            push_item(fresh_item(OP_TICK));
        end
        slots = CHARS + 3 + $urandom_range(0, 3);
        for (int i = 0; i < slots; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                push_item(host_item());
            else if (r < 15)
                push_item(button_report());
            else if (r < 18)
                push_item(fresh_item(OP_TICK));
            push_item(fresh_item(OP_TX_SLOT));
        end
        push_item(fresh_item(OP_READ_BTN));
    endtask

    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_delay(logic [DELAY_W-1:0] v);
        int target;
        target = delay_done + 1;
        delay_writes.push_back(v);
        while (delay_done < target)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int delay_value, bit write_it, int budget);
        int start;
        start = pushed_cnt;
        if (write_it)
            write_delay(DELAY_W'(delay_value));
        while (pushed_cnt - start < budget) begin
            if ($urandom_range(0, 99) < 60)
                gen_frame(delay_value);
            else
                repeat ($urandom_range(1, 6)) push_item(noise_item());
        end
        wait_idle();
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("cycle %0d: %s mismatch on result %0d: got 0x%0h, expected 0x%0h",
                     cycle_cnt, what, checked_cnt, got, want);
    endtask

    // ---------------------------------------------------------------- input driver
    always @(posedge i_clk) begin : drive_items
        bit free;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            free = !in_valid || in_ready;
            if (in_valid && in_ready) begin
                expected_results.push_back(advance_terminal(in_data));
                accepted_cnt++;
                if ($urandom_range(0, 63) == 0)
                    quiet <= !quiet;
            end
            if (free) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    in_gap = draw_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- delay register writes
    always @(posedge i_clk) begin : drive_delay
        if (!i_rst_n) begin
            cfg_valid <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            m_delay = cfg_data;
            delay_done++;
            cfg_valid <= 1'b0;
        end else if (!cfg_valid && delay_writes.size() > 0) begin
            cfg_data  <= delay_writes.pop_front();
            cfg_valid <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- result monitor
    always @(posedge i_clk) begin : watch_results
        t_result want;
        int      g;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            res_hold = 0;
        end else if (res_valid && res_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", res_data, 0);
            end else begin
                want = expected_results.pop_front();
                if (res_data.tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", res_data.tx_valid, want.tx_valid);
                if (res_data.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", res_data.tx_byte, want.tx_byte);
                if (res_data.tx_ninth !== want.tx_ninth)
                    report_mismatch("tx_ninth", res_data.tx_ninth, want.tx_ninth);
                if (res_data.frame_done !== want.frame_done)
                    report_mismatch("frame_done", res_data.frame_done, want.frame_done);
                if (res_data.button_value !== want.button_value)
                    report_mismatch("button_value", res_data.button_value, want.button_value);
            end
            checked_cnt++;
            g = draw_gap();
            if (g > 0) begin
                res_ready <= 1'b0;
                res_hold = g - 1;
            end else begin
                res_ready <= 1'b1;
            end
        end else if (res_hold > 0) begin
            res_ready <= 1'b0;
            res_hold--;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("telemetry_terminal_link_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus and phases
    initial begin : stimulus
        t_item it;
        int    p;

        // predictor starts from the reset state
        m_delay = DELAY_RESET;
        for (p = 0; p <= CHARS; p++)
            m_store[p] = SPACE_CHAR;
        m_cursor    = clamp_cursor(LINE_ONE);
        m_send_idx  = '0;
        m_sending   = 1'b0;
        m_countdown = '0;
        m_buttons   = '0;
        m_last_read = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle tick and slot, nothing to read, unused opcode
        push_item(fresh_item(OP_TICK));
        push_item(fresh_item(OP_TX_SLOT));
        push_item(fresh_item(OP_READ_BTN));
        push_item(fresh_item(3'd7));
        // character extremes at the start of line one
        it = fresh_item(OP_WRITE_CHR); it.char_in = 8'h00; push_item(it);
        it = fresh_item(OP_WRITE_CHR); it.char_in = 8'hFF; push_item(it);
        // cursor past the store saturates, writes at the last position stick there
        it = fresh_item(OP_SET_CUR); it.cursor_position = 6'd63; push_item(it);
        it = fresh_item(OP_WRITE_CHR); it.char_in = 8'hA5; push_item(it);
        it = fresh_item(OP_WRITE_CHR); it.char_in = 8'h5A; push_item(it);
        // hidden position zero, never swept or sent
        it = fresh_item(OP_SET_CUR); it.cursor_position = 6'd0; push_item(it);
        it = fresh_item(OP_WRITE_CHR); it.char_in = 8'h7E; push_item(it);
        it = fresh_item(OP_SET_CUR); it.cursor_position = 6'(CHARS); push_item(it);
        // each clear selector, the spare code included
        it = fresh_item(OP_CLEAR); it.clear_line = CLR_LINE1; push_item(it);
        it = fresh_item(OP_CLEAR); it.clear_line = CLR_LINE2; push_item(it);
        it = fresh_item(OP_CLEAR); it.clear_line = 2'd3;      push_item(it);
        it = fresh_item(OP_CLEAR); it.clear_line = CLR_ALL;   push_item(it);
        // rejected reports: line error, ninth bit set, low nibble set
        it = button_report(); it.rx_error = 1'b1;        push_item(it);
        it = button_report(); it.rx_ninth = 1'b1;        push_item(it);
        it = button_report(); it.rx_byte  = 8'h01;       push_item(it);
        // accepted reports, a changed read, then an unchanged one
        it = button_report(); it.rx_byte  = 8'h00;       push_item(it);
        push_item(fresh_item(OP_READ_BTN));
        push_item(fresh_item(OP_READ_BTN));
        it = button_report(); it.rx_byte  = 8'hF0;       push_item(it);
        push_item(fresh_item(OP_READ_BTN));
        it = button_report(); it.rx_byte  = 8'h50;       push_item(it);
        push_item(fresh_item(OP_READ_BTN));

        // random phases across delay settings, extremes and the zero case among them
        run_phase(DELAY_RESET, 1'b0, 150);
        run_phase(1, 1'b1, 200);
        run_phase($urandom_range(2, 8), 1'b1, 200);
        run_phase(255, 1'b1, 300);
        run_phase(0, 1'b1, 120);
        run_phase($urandom_range(9, 40), 1'b1, 150);
        run_phase(DELAY_RESET, 1'b1, 100);

        $display("%0d items over %0d delay settings, %0d results compared, %0d frames closed",
                 accepted_cnt, delay_done + 1, checked_cnt, frames_closed);
        if (mismatch_cnt == 0)
            $display("telemetry_terminal_link_unit regression: pass");
        else
            $display("telemetry_terminal_link_unit regression: fail");
        $finish;
    end

endmodule

// File: files.f
sv/ttl_pkg.sv
sv/ttl_ram.sv
sv/telemetry_terminal_link_unit.sv
sv/ttl_checker.sv
sim/tb_telemetry_terminal_link_unit.sv
